[rtl/bstt_pkg.sv]
// Shared types and constants for the bounded-score transposition table.
// Table geometry, entry layout, kind and outcome codes, result record.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bstt_pkg;

  localparam int INDEX_BITS = 16;
  localparam int DEPTH_BITS = 6;

  localparam int KEY_W      = 64;
  localparam int SCORE_W    = 32;
  localparam int REQ_DEPTH_W = 6;
  localparam int SQ_W       = 6;
  localparam int KIND_W     = 2;
  localparam int OUTCOME_W  = 2;

  // wide enough for both the asked depth and the stored depth
  localparam int CMP_W = (DEPTH_BITS > REQ_DEPTH_W) ? DEPTH_BITS : REQ_DEPTH_W;

  localparam int IN_TDATA_W  = 184;  // 179 bits of fields, zero padded
  localparam int OUT_TDATA_W = 112;  // 109 bits of fields, zero padded

  localparam logic [KIND_W-1:0] KIND_EXACT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOWER = 2'd1;
  localparam logic [KIND_W-1:0] KIND_UPPER = 2'd2;

  localparam logic [OUTCOME_W-1:0] OUT_NONE   = 2'd0;
  localparam logic [OUTCOME_W-1:0] OUT_EXACT  = 2'd1;
  localparam logic [OUTCOME_W-1:0] OUT_BOUND  = 2'd2;
  localparam logic [OUTCOME_W-1:0] OUT_NARROW = 2'd3;

  localparam logic OP_PROBE = 1'b0;
  localparam logic OP_STORE = 1'b1;

  typedef struct packed {
    logic            valid;
    logic [SQ_W-1:0] from_sq;
    logic [SQ_W-1:0] to_sq;
  } move_t;

  typedef struct packed {
    logic [KEY_W-1:0]      key;
    logic [SCORE_W-1:0]    score;
    logic [DEPTH_BITS-1:0] depth;
    logic [KIND_W-1:0]     kind;
    move_t                 move;
  } entry_t;

  typedef struct packed {
    logic [OUTCOME_W-1:0] outcome;
    logic [SCORE_W-1:0]   alpha;
    logic [SCORE_W-1:0]   beta;
    logic [SCORE_W-1:0]   score;
    logic [SQ_W-1:0]      hint_from;
    logic [SQ_W-1:0]      hint_to;
    logic                 hint_valid;
  } res_t;

endpackage

`default_nettype wire

[rtl/bstt_probe.sv]
// Probe evaluation: hit test on a table entry and alpha/beta adjustment.
// Depends on bstt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bstt_probe (
  input  bstt_pkg::entry_t                        ent,
  input  logic [bstt_pkg::KEY_W-1:0]              key,
  input  logic [bstt_pkg::REQ_DEPTH_W-1:0]        depth,
  input  logic [bstt_pkg::SCORE_W-1:0]            alpha,
  input  logic [bstt_pkg::SCORE_W-1:0]            beta,
  output bstt_pkg::res_t                          res
);
  import bstt_pkg::*;

  logic                      hit;
  logic signed [SCORE_W-1:0] sc;
  logic signed [SCORE_W-1:0] a_adj;
  logic signed [SCORE_W-1:0] b_adj;

  assign hit = (ent.key == key) && (CMP_W'(ent.depth) >= CMP_W'(depth));
  assign sc  = $signed(ent.score);

  always_comb begin
    a_adj = $signed(alpha);
    b_adj = $signed(beta);
    if (ent.kind == KIND_LOWER && sc > a_adj) begin
      a_adj = sc;
    end
    if (ent.kind == KIND_UPPER && sc < b_adj) begin
      b_adj = sc;
    end

    res.outcome    = OUT_NONE;
    res.alpha      = alpha;
    res.beta       = beta;
    res.score      = '0;
    res.hint_from  = '0;
    res.hint_to    = '0;
    res.hint_valid = 1'b0;

    if (hit) begin
      res.score = ent.score;
      if (ent.move.valid) begin
        res.hint_from  = ent.move.from_sq;
        res.hint_to    = ent.move.to_sq;
        res.hint_valid = 1'b1;
      end
      if (ent.kind == KIND_EXACT) begin
        res.outcome = OUT_EXACT;
      end else begin
        res.alpha   = a_adj;
        res.beta    = b_adj;
        res.outcome = (a_adj >= b_adj) ? OUT_BOUND : OUT_NARROW;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/bounded_score_transposition_table.sv]
// Bounded-score transposition table: top level with the entry memory.
// Depends on bstt_pkg and bstt_probe.
//
// Usage:
//   Requests enter on in_* (tuser = operation, 0 probe / 1 store) and one
//   result per request leaves on out_* (tuser = outcome).
//   A probe looks up the entry picked by the low INDEX_BITS key bits; a store
//   overwrites that entry and answers with outcome zero.
//   Each request is first read from the table synchronously (stores write
//   in the same cycle), then evaluated and loaded into the output register.
//   A new request is not accepted until the previous one has been evaluated,
//   as set by the read-then-evaluate loop of the state machine. A result is
//   valid on out_* once the evaluate step has loaded the output register.
//   The output register lets the next request be read while a result waits.
//   If out_tready stays low, the next request finishes its read and then
//   holds until the output register frees; in_tready stays low meanwhile.
//   After reset a clearing pass writes zero to all 2^INDEX_BITS entries,
//   one per cycle (65536 entries at the default size); in_tready is low
//   until it completes.
`timescale 1ns / 1ps
`default_nettype none

module bounded_score_transposition_table (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // [63:0] key, [69:64] depth, [101:70] alpha, [133:102] beta,
  // [165:134] best_score, [171:166] move_from, [177:172] move_to,
  // [178] move_valid
  input  logic [bstt_pkg::IN_TDATA_W-1:0]      in_tdata,
  // [0] operation
  input  logic                                 in_tuser,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // [31:0] alpha_out, [63:32] beta_out, [95:64] score_out,
  // [101:96] hint_from, [107:102] hint_to, [108] hint_valid
  output logic [bstt_pkg::OUT_TDATA_W-1:0]     out_tdata,
  // [1:0] outcome
  output logic [bstt_pkg::OUTCOME_W-1:0]       out_tuser
);
  import bstt_pkg::*;

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_EVAL} state_t;

  localparam int TABLE_SIZE = 1 << INDEX_BITS;

  entry_t mem [TABLE_SIZE];

  state_t                 state_r;
  logic [INDEX_BITS-1:0]  clr_idx_r;
  logic                   req_op_r;
  logic [KEY_W-1:0]       req_key_r;
  logic [REQ_DEPTH_W-1:0] req_depth_r;
  logic [SCORE_W-1:0]     req_alpha_r;
  logic [SCORE_W-1:0]     req_beta_r;
  entry_t                 rd_ent_r;
  logic                   out_valid_r;
  res_t                   out_res_r;

  // request fields
  logic [KEY_W-1:0]          f_key;
  logic [REQ_DEPTH_W-1:0]    f_depth;
  logic [SCORE_W-1:0]        f_alpha;
  logic [SCORE_W-1:0]        f_beta;
  logic [SCORE_W-1:0]        f_best;
  logic [SQ_W-1:0]           f_from;
  logic [SQ_W-1:0]           f_to;
  logic                      f_mvalid;
  logic [INDEX_BITS-1:0]     f_idx;

  logic                      in_acc;
  logic                      out_free;
  logic                      wr_en;
  logic [INDEX_BITS-1:0]     wr_idx;
  entry_t                    wr_ent;
  entry_t                    st_ent;
  logic [CMP_W-1:0]          depth_w;
  logic [CMP_W-1:0]          dmax_w;
  res_t                      probe_res;
  res_t                      res_nxt;

  assign f_key    = in_tdata[63:0];
  assign f_depth  = in_tdata[69:64];
  assign f_alpha  = in_tdata[101:70];
  assign f_beta   = in_tdata[133:102];
  assign f_best   = in_tdata[165:134];
  assign f_from   = in_tdata[171:166];
  assign f_to     = in_tdata[177:172];
  assign f_mvalid = in_tdata[178];
  assign f_idx    = f_key[INDEX_BITS-1:0];

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  // entry built by a store; depth saturates at the stored width
  always_comb begin
    depth_w = CMP_W'(f_depth);
    dmax_w  = CMP_W'({DEPTH_BITS{1'b1}});
    st_ent.key   = f_key;
    st_ent.score = f_best;
    st_ent.depth = (depth_w > dmax_w) ? DEPTH_BITS'(dmax_w) : DEPTH_BITS'(depth_w);
    if ($signed(f_best) <= $signed(f_alpha)) begin
      st_ent.kind = KIND_UPPER;
    end else if ($signed(f_best) >= $signed(f_beta)) begin
      st_ent.kind = KIND_LOWER;
    end else begin
      st_ent.kind = KIND_EXACT;
    end
    st_ent.move.valid   = f_mvalid;
    st_ent.move.from_sq = f_mvalid ? f_from : '0;
    st_ent.move.to_sq   = f_mvalid ? f_to : '0;
  end

  always_comb begin
    if (state_r == S_CLEAR) begin
      wr_en  = 1'b1;
      wr_idx = clr_idx_r;
      wr_ent = '0;
    end else begin
      wr_en  = in_acc && (in_tuser == OP_STORE);
      wr_idx = f_idx;
      wr_ent = st_ent;
    end
  end

  // read data register only moves on an accepted request, so it holds
  // while the result waits for the output register
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_ent;
    end
    if (in_acc) begin
      rd_ent_r <= mem[f_idx];
    end
  end

  bstt_probe u_probe (
    .ent   (rd_ent_r),
    .key   (req_key_r),
    .depth (req_depth_r),
    .alpha (req_alpha_r),
    .beta  (req_beta_r),
    .res   (probe_res)
  );

  always_comb begin
    if (req_op_r == OP_STORE) begin
      res_nxt       = '0;
      res_nxt.alpha = req_alpha_r;
      res_nxt.beta  = req_beta_r;
    end else begin
      res_nxt = probe_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == S_EVAL && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          clr_idx_r <= clr_idx_r + 1'b1;
          if (clr_idx_r == '1) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            state_r <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
    if (in_acc) begin
      req_op_r    <= in_tuser;
      req_key_r   <= f_key;
      req_depth_r <= f_depth;
      req_alpha_r <= f_alpha;
      req_beta_r  <= f_beta;
    end
    if (state_r == S_EVAL && out_free) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.outcome;
  assign out_tdata  = {3'b000, out_res_r.hint_valid, out_res_r.hint_to,
                       out_res_r.hint_from, out_res_r.score, out_res_r.beta,
                       out_res_r.alpha};

endmodule

`default_nettype wire

[test/tb.sv]
// Self-checking bench for bounded_score_transposition_table: directed rows, then random
// probe/store traffic over aliased keys, checked against a shadow copy of the entry memory.
// Depends on bstt_pkg and the RTL under rtl/.
`timescale 1ns / 1ps

module tb;
  import bstt_pkg::*;

  localparam int WATCHDOG_LIMIT = 200000;  // covers the clearing pass after reset
  localparam int LONG_HOLD      = 250;
  localparam int RANDOM_ITEMS   = 1880;
  localparam int DEPTH_MAX      = (1 << DEPTH_BITS) - 1;
  localparam int S_MIN          = 32'sh8000_0000;
  localparam int S_MAX          = 32'sh7fff_ffff;

  typedef struct {
    logic                      op;
    logic [KEY_W-1:0]          key;
    logic [REQ_DEPTH_W-1:0]    depth;
    logic signed [SCORE_W-1:0] alpha;
    logic signed [SCORE_W-1:0] beta;
    logic signed [SCORE_W-1:0] best;
    logic [SQ_W-1:0]           mfrom;
    logic [SQ_W-1:0]           mto;
    logic                      mvalid;
  } request_t;

  // typed rows carry an echo-style answer: bounds repeated, score and hint zero
  typedef struct {
    request_t             rq;
    bit                   typed;
    logic [OUTCOME_W-1:0] oc;
  } row_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUTCOME_W-1:0]   out_tuser;

  entry_t        tt_shadow[int unsigned];
  res_t          answers_due[$];
  row_t          dir_rows[$];
  logic [KEY_W-1:0] key_pool[64];
  logic [KEY_W-1:0] recent_keys[$];
  bit            sender_burst;
  int            errors;
  int            results_seen;
  int            quiet_cycles;
  int            n_store;
  int            n_probe;
  int            oc_count[4];

  bounded_score_transposition_table i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Shadow of the entry memory: applies one request, returns the answer it should get.
  function automatic res_t tt_apply(input request_t r);
    entry_t                    e;
    res_t                      res;
    int unsigned               idx;
    int                        d;
    logic signed [SCORE_W-1:0] sc;
    logic signed [SCORE_W-1:0] a;
    logic signed [SCORE_W-1:0] b;
    idx = r.key[INDEX_BITS-1:0];
    a = r.alpha;
    b = r.beta;
    res = '0;
    res.alpha = a;
    res.beta = b;
    res.outcome = OUT_NONE;
    if (r.op == OP_STORE) begin
      d = r.depth;
      if (d > DEPTH_MAX) d = DEPTH_MAX;
      e.key = r.key;
      e.score = r.best;
      e.depth = d[DEPTH_BITS-1:0];
      if (r.best <= a) e.kind = KIND_UPPER;
      else if (r.best >= b) e.kind = KIND_LOWER;
      else e.kind = KIND_EXACT;
      if (r.mvalid) begin
        e.move.valid = 1'b1;
        e.move.from_sq = r.mfrom;
        e.move.to_sq = r.mto;
      end else begin
        e.move = '0;
      end
      tt_shadow[idx] = e;
      return res;
    end
    if (tt_shadow.exists(idx)) e = tt_shadow[idx];
    else e = '0;
    if (e.key != r.key || int'(e.depth) < int'(r.depth)) return res;
    sc = e.score;
    res.score = e.score;
    if (e.move.valid) begin
      res.hint_from = e.move.from_sq;
      res.hint_to = e.move.to_sq;
      res.hint_valid = 1'b1;
    end
    if (e.kind == KIND_EXACT) begin
      res.outcome = OUT_EXACT;
      return res;
    end
    if (e.kind == KIND_LOWER && sc > a) a = sc;
    if (e.kind == KIND_UPPER && sc < b) b = sc;
    res.alpha = a;
    res.beta = b;
    res.outcome = (a >= b) ? OUT_BOUND : OUT_NARROW;
    return res;
  endfunction

  function automatic request_t mk_req(input logic op, input logic [KEY_W-1:0] key,
                                      input int depth, input int alpha, input int beta,
                                      input int best, input int mfrom, input int mto,
                                      input bit mvalid);
    request_t r;
    r.op = op;
    r.key = key;
    r.depth = REQ_DEPTH_W'(depth);
    r.alpha = alpha;
    r.beta = beta;
    r.best = best;
    r.mfrom = SQ_W'(mfrom);
    r.mto = SQ_W'(mto);
    r.mvalid = mvalid;
    return r;
  endfunction

  function automatic void add_row(input request_t rq, input bit typed,
                                  input logic [OUTCOME_W-1:0] oc);
    row_t row;
    row.rq = rq;
    row.typed = typed;
    row.oc = oc;
    dir_rows = {dir_rows, row};
  endfunction

  // mostly short gaps, a few long ones
  function automatic int idle_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int pick_score();
    int p;
    p = $urandom_range(0, 99);
    if (p < 70) return $urandom_range(0, 400) - 200;
    if (p < 85) return $urandom;
    case ($urandom_range(0, 4))
      0: return S_MIN;
      1: return S_MAX;
      2: return S_MIN + 1;
      3: return S_MAX - 1;
      default: return 0;
    endcase
  endfunction

  function automatic request_t random_request();
    request_t r;
    int       p;
    int       t;
    r.op = ($urandom_range(0, 99) < 45) ? OP_STORE : OP_PROBE;
    p = $urandom_range(0, 99);
    if (r.op == OP_PROBE && recent_keys.size() > 0 && p < 35)
      r.key = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
    else if (p < 88)
      r.key = key_pool[$urandom_range(0, 63)];
    else
      r.key = {$urandom, $urandom};
    if (r.op == OP_PROBE && $urandom_range(0, 99) < 60)
      r.depth = REQ_DEPTH_W'($urandom_range(0, 31));
    else r.depth = REQ_DEPTH_W'($urandom_range(0, 63));
    r.alpha = pick_score();
    r.beta = pick_score();
    if ($urandom_range(0, 99) < 85 && r.alpha > r.beta) begin
      t = r.alpha;
      r.alpha = r.beta;
      r.beta = t;
    end
    r.best = pick_score();
    r.mfrom = SQ_W'($urandom_range(0, 63));
    r.mto = SQ_W'($urandom_range(0, 63));
    r.mvalid = ($urandom_range(0, 3) != 0);
    return r;
  endfunction

  // Called at a falling edge; returns at the falling edge after the request is taken.
  task automatic send_request(input request_t r, input bit typed,
                              input logic [OUTCOME_W-1:0] oc);
    res_t answer;
    int   gap;
    gap = sender_burst ? 0 : idle_gap();
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata = {{(IN_TDATA_W - 179){1'b0}}, r.mvalid, r.mto, r.mfrom,
                r.best, r.beta, r.alpha, r.depth, r.key};
    in_tuser = r.op;
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    answer = tt_apply(r);
    if (typed) begin
      answer = '0;
      answer.outcome = oc;
      answer.alpha = r.alpha;
      answer.beta = r.beta;
    end
    answers_due = {answers_due, answer};
    if (r.op == OP_STORE) begin
      n_store++;
      recent_keys = {recent_keys, r.key};
      if (recent_keys.size() > 8) void'(recent_keys.pop_front());
    end else begin
      n_probe++;
    end
    @(negedge clk);
  endtask

  task automatic report_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  // receiver: random stalls, bursts of steady ready, and one long hold-off
  initial begin
    bit hold_done;
    int n;
    hold_done = 1'b0;
    out_tready = 1'b0;
    @(negedge clk);
    wait (rst_n);
    @(negedge clk);
    forever begin
      if (!hold_done && results_seen >= 400) begin
        hold_done = 1'b1;
        out_tready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end else if ($urandom_range(0, 9) == 0) begin
        out_tready = 1'b1;
        repeat ($urandom_range(30, 120)) @(negedge clk);
      end else begin
        n = idle_gap();
        if (n > 0) begin
          out_tready = 1'b0;
          repeat (n) @(negedge clk);
        end
        out_tready = 1'b1;
        @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (answers_due.size() == 0) begin
        $error("result with no request outstanding: outcome %0d", out_tuser);
        errors++;
      end else begin
        want = answers_due.pop_front();
        oc_count[want.outcome]++;
        report_field("outcome", want.outcome, out_tuser);
        report_field("alpha_out", $signed(want.alpha), $signed(out_tdata[31:0]));
        report_field("beta_out", $signed(want.beta), $signed(out_tdata[63:32]));
        report_field("score_out", $signed(want.score), $signed(out_tdata[95:64]));
        report_field("hint_from", want.hint_from, out_tdata[101:96]);
        report_field("hint_to", want.hint_to, out_tdata[107:102]);
        report_field("hint_valid", want.hint_valid, out_tdata[108]);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
               quiet_cycles, answers_due.size());
      $display("** bounded_score_transposition_table: FAILED **");
      $finish;
    end
  end

  initial begin
    logic [KEY_W-1:0]    k1;
    logic [KEY_W-1:0]    k2;
    logic [KEY_W-1:0]    k3;
    logic [KEY_W-1:0]    k4;
    logic [INDEX_BITS-1:0] idx_pool[16];
    errors = 0;
    results_seen = 0;
    quiet_cycles = 0;
    n_store = 0;
    n_probe = 0;
    oc_count = '{0, 0, 0, 0};
    sender_burst = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;

    k1 = 64'hFFFF_FFFF_FFFF_FFFF;
    k2 = 64'h8000_0000_0000_ABCD;
    k3 = 64'h0123_4567_89AB_0042;
    k4 = 64'h5A5A_A5A5_0F0F_7777;
    // fresh memory: key zero / depth zero is an exact hit, others miss
    add_row(mk_req(OP_PROBE, 64'h0, 0, -5, 7, 0, 0, 0, 0), 1'b1, OUT_EXACT);
    add_row(mk_req(OP_PROBE, 64'h0, 1, S_MIN, S_MAX, 0, 0, 0, 0), 1'b1, OUT_NONE);
    add_row(mk_req(OP_PROBE, 64'h1234, 0, 0, 1, 0, 0, 0, 0), 1'b1, OUT_NONE);
    add_row(mk_req(OP_STORE, k1, 63, -10, 10, 3, 63, 63, 1), 1'b1, OUT_NONE);
    add_row(mk_req(OP_PROBE, k1, 63, S_MIN, S_MAX, 0, 0, 0, 0), 1'b0, OUT_NONE);
    // lower bound, move flagged invalid so squares drop to zero
    add_row(mk_req(OP_STORE, k2, 20, 0, 100, 150, 21, 42, 0), 1'b1, OUT_NONE);
    add_row(mk_req(OP_PROBE, k2, 20, 50, 200, 0, 0, 0, 0), 1'b0, OUT_NONE);
    add_row(mk_req(OP_PROBE, k2, 5, 50, 120, 0, 0, 0, 0), 1'b0, OUT_NONE);
    add_row(mk_req(OP_PROBE, k2, 21, 0, 100, 0, 0, 0, 0), 1'b1, OUT_NONE);
    add_row(mk_req(OP_PROBE, k2 ^ (64'h1 << 40), 0, 0, 100, 0, 0, 0, 0), 1'b1, OUT_NONE);
    // upper bound
    add_row(mk_req(OP_STORE, k3, 7, 0, 100, -40, 1, 2, 1), 1'b1, OUT_NONE);
    add_row(mk_req(OP_PROBE, k3, 7, -100, 50, 0, 0, 0, 0), 1'b0, OUT_NONE);
    add_row(mk_req(OP_PROBE, k3, 0, -20, 50, 0, 0, 0, 0), 1'b0, OUT_NONE);
    // bounds already crossed on entry
    add_row(mk_req(OP_PROBE, k3, 3, 10, 5, 0, 0, 0, 0), 1'b0, OUT_NONE);
    add_row(mk_req(OP_PROBE, k2, 0, 300, 200, 0, 0, 0, 0), 1'b0, OUT_NONE);
    // score extremes, best equal to alpha then to beta
    add_row(mk_req(OP_STORE, k4, 0, S_MIN, S_MAX, S_MIN, 0, 0, 1), 1'b1, OUT_NONE);
    add_row(mk_req(OP_PROBE, k4, 0, S_MIN, S_MAX, 0, 0, 0, 0), 1'b0, OUT_NONE);
    add_row(mk_req(OP_STORE, k4, 1, S_MIN, S_MAX, S_MAX, 63, 0, 1), 1'b1, OUT_NONE);
    add_row(mk_req(OP_PROBE, k4, 1, S_MIN, S_MAX, 0, 0, 0, 0), 1'b0, OUT_NONE);
    add_row(mk_req(OP_STORE, 64'h0, 63, -1, 1, 0, 0, 63, 1), 1'b1, OUT_NONE);
    add_row(mk_req(OP_PROBE, 64'h0, 62, 0, 0, 0, 0, 0, 0), 1'b0, OUT_NONE);
    add_row(mk_req(OP_STORE, k1, 0, 5, 5, 5, 0, 0, 0), 1'b1, OUT_NONE);
    add_row(mk_req(OP_PROBE, k1, 0, 0, 9, 0, 0, 0, 0), 1'b0, OUT_NONE);

    // few table slots, several keys per slot so aliases evict each other
    foreach (idx_pool[i]) idx_pool[i] = INDEX_BITS'($urandom);
    foreach (key_pool[i])
      key_pool[i] = {$urandom, 16'($urandom_range(0, 65535)), idx_pool[i % 16]};

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_rows[i]) send_request(dir_rows[i].rq, dir_rows[i].typed, dir_rows[i].oc);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 150 == 0) sender_burst = ($urandom_range(0, 3) == 0);
      send_request(random_request(), 1'b0, OUT_NONE);
    end
    in_tvalid = 1'b0;

    while (answers_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d requests (%0d stores, %0d probes) over aliased keys, with stalls,",
             n_store + n_probe, n_store, n_probe);
    $display("bursts and a long output hold-off; %0d results: %0d exact, %0d cutoff, %0d narrowed",
             results_seen, oc_count[OUT_EXACT], oc_count[OUT_BOUND], oc_count[OUT_NARROW]);
    if (errors == 0) begin
      $display("** bounded_score_transposition_table: PASSED **");
    end else begin
      $display("** bounded_score_transposition_table: FAILED **");
    end
    $finish;
  end

endmodule
